[sv/opi_pkg.sv]
// opi_pkg: widths, controller command struct, state codes and the cordic
// arctangent table for the odometry pose integrator
// no dependencies
package opi_pkg;

    localparam int POS_W      = 32;
    localparam int HEAD_W     = 16;
    localparam int DELTA_W    = 24;
    localparam int ANGLE_BITS = 16;
    localparam int ROTATION_STEPS = 16;

    localparam int TABLE_LEN  = 24;
    localparam int TAB_IW     = 5;
    localparam int GUARD_BITS = 8;
    localparam int INV_GAIN_W = 30;
    localparam logic [INV_GAIN_W-1:0] INV_GAIN_Q30 = 30'd652032874;

    // number of micro-rotations actually run
    localparam int STEP_N = (ROTATION_STEPS < TABLE_LEN) ? ROTATION_STEPS : TABLE_LEN;
    localparam int IDX_W  = (STEP_N > 1) ? $clog2(STEP_N) : 1;
    localparam logic [IDX_W-1:0] STEP_LAST = IDX_W'(STEP_N - 1);

    // rotation datapath: offset with guard bits, sign, fold and cordic growth
    localparam int XW   = DELTA_W + GUARD_BITS + 4;
    localparam int LO_W = XW / 2;
    localparam int HI_W = XW - LO_W;
    localparam int MA_W = LO_W + 1;
    localparam int PW   = MA_W + INV_GAIN_W + 1;
    localparam int RSH  = 30 + GUARD_BITS;
    localparam int AW   = RSH + POS_W;
    localparam logic [AW-1:0] ROUND_C = AW'(1) << (RSH - 1);

    // residual angle format
    localparam int ZW   = ANGLE_BITS + 2;
    localparam int SH_L = (ANGLE_BITS >= HEAD_W) ? (ANGLE_BITS - HEAD_W) : 0;
    localparam int SH_R = (ANGLE_BITS <  HEAD_W) ? (HEAD_W - ANGLE_BITS) : 0;

    // controller state codes
    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE   = 3'd0;
    localparam logic [ST_W-1:0] ST_ROT    = 3'd1;
    localparam logic [ST_W-1:0] ST_MLO    = 3'd2;
    localparam logic [ST_W-1:0] ST_MHI    = 3'd3;
    localparam logic [ST_W-1:0] ST_MSUM   = 3'd4;
    localparam logic [ST_W-1:0] ST_COMMIT = 3'd5;

    typedef struct packed {
        logic             load;
        logic             rot;
        logic [IDX_W-1:0] step;
        logic             mul_lo;
        logic             mul_hi;
        logic             mul_sum;
        logic             commit;
    } opi_cmd_t;

    // arctan(2^-i) as a fraction of the full circle, 32 bits per turn
    localparam logic [31:0] ATAN_TURN32 [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    function automatic logic [ZW-1:0] atan_step(input logic [IDX_W-1:0] i);
        logic [31:0] t;
        t = ATAN_TURN32[TAB_IW'(i)];
        return ZW'(t >> (32 - ANGLE_BITS));
    endfunction

endpackage

[sv/odometry_pose_integrator_unit.sv]
// odometry pose integrator: one request is a relative odometry step, one result the new pose
// a taken request runs the cordic micro-rotations, then the low and high gain products and
// their sum, then commits the new pose into the output register; no new request is taken
// until the commit; a waiting result does not block the next request, only its commit
// reset: synchronous active-low aresetn clears the pose to the origin, heading zero
// depends on opi_pkg, opi_ctrl, opi_datapath
module odometry_pose_integrator_unit
    import opi_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // delta_x[23:0], delta_y[47:24], delta_heading[63:48]
    input  logic        s_tuser,   // start_new
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // pose_x[31:0], pose_y[63:32], pose_heading[79:64]
);

    opi_cmd_t cmd;

    logic signed [POS_W-1:0]  pose_x, pose_y;
    logic signed [HEAD_W-1:0] pose_heading;

    opi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    opi_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .start_new     (s_tuser),
        .delta_x       (signed'(s_tdata[23:0])),
        .delta_y       (signed'(s_tdata[47:24])),
        .delta_heading (signed'(s_tdata[63:48])),
        .pose_x        (pose_x),
        .pose_y        (pose_y),
        .pose_heading  (pose_heading)
    );

    assign m_tdata = {pose_heading, pose_y, pose_x};

`ifndef SYNTHESIS
    a_load_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> (s_tvalid && s_tready))
        else $error("step loaded without an accepted request");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (!s_tready && cmd.rot))
        else $error("rotation did not start after a request");

    a_commit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_tvalid || m_tready))
        else $error("pose committed over an untaken result");

    a_commit_raises_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_tvalid)
        else $error("committed pose not presented");
`endif

endmodule

[sv/opi_ctrl.sv]
// opi_ctrl: sequencing state machine for the pose integrator
// depends on opi_pkg; drives the datapath through opi_cmd_t
module opi_ctrl
    import opi_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    output logic     m_tvalid,
    input  logic     m_tready,
    output opi_cmd_t cmd
);

    logic [ST_W-1:0]  state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             slot_free;

    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.step   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_ROT;
                end
            end
            ST_ROT: begin
                cmd.rot = 1'b1;
                if (cnt_reg == STEP_LAST) begin
                    state_next = ST_MLO;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MLO: begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MHI;
            end
            ST_MHI: begin
                cmd.mul_hi = 1'b1;
                state_next = ST_MSUM;
            end
            ST_MSUM: begin
                cmd.mul_sum = 1'b1;
                state_next  = ST_COMMIT;
            end
            ST_COMMIT: begin
                // wait until the output register can take the new pose
                if (slot_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        priority if (cmd.commit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[sv/opi_datapath.sv]
// opi_datapath: pose registers, cordic rotator and gain correction multipliers
// depends on opi_pkg; steered by opi_ctrl via opi_cmd_t
module opi_datapath
    import opi_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  opi_cmd_t                 cmd,
    input  logic                     start_new,
    input  logic signed [DELTA_W-1:0] delta_x,
    input  logic signed [DELTA_W-1:0] delta_y,
    input  logic signed [HEAD_W-1:0]  delta_heading,
    output logic signed [POS_W-1:0]   pose_x,
    output logic signed [POS_W-1:0]   pose_y,
    output logic signed [HEAD_W-1:0]  pose_heading
);

    logic [POS_W-1:0]  gx_reg, gy_reg;
    logic [HEAD_W-1:0] gh_reg;
    logic [HEAD_W-1:0] turn_reg;

    logic signed [XW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;
    logic signed [PW-1:0] px_reg, py_reg;
    logic signed [AW-1:0] ax_reg, ay_reg;

    logic [POS_W-1:0] px_out_reg, py_out_reg;
    logic [HEAD_W-1:0] ph_out_reg;

    // load: fold the heading into a half circle and scale the offset
    logic [HEAD_W-1:0]     h_use, h_fold;
    logic                  fold;
    logic signed [31:0]    h_ext, z_wide;
    logic signed [XW-1:0]  x_ld, y_ld, x_init, y_init;

    always_comb begin
        h_use  = start_new ? '0 : gh_reg;
        fold   = h_use[HEAD_W-1] ^ h_use[HEAD_W-2];
        h_fold = fold ? (h_use ^ {1'b1, {(HEAD_W-1){1'b0}}}) : h_use;
        h_ext  = 32'(signed'(h_fold));
        z_wide = (ANGLE_BITS >= HEAD_W) ? (h_ext <<< SH_L) : (h_ext >>> SH_R);
        x_ld   = XW'(delta_x) <<< GUARD_BITS;
        y_ld   = XW'(delta_y) <<< GUARD_BITS;
        x_init = fold ? -x_ld : x_ld;
        y_init = fold ? -y_ld : y_ld;
    end

    // one micro-rotation
    logic signed [XW-1:0] xs, ys;
    logic signed [ZW-1:0] a_step;
    logic                 z_pos;

    assign xs     = x_reg >>> cmd.step;
    assign ys     = y_reg >>> cmd.step;
    assign a_step = signed'(atan_step(cmd.step));
    assign z_pos  = !z_reg[ZW-1];

    // gain correction: one multiplier per axis, low half then high half
    logic signed [MA_W-1:0]       mx_a, my_a;
    logic signed [INV_GAIN_W:0]   gain_s;
    logic signed [PW-1:0]         mx_p, my_p;

    assign gain_s = signed'({1'b0, INV_GAIN_Q30});
    assign mx_a   = cmd.mul_hi ? MA_W'(signed'(x_reg[XW-1:LO_W]))
                               : signed'({1'b0, x_reg[LO_W-1:0]});
    assign my_a   = cmd.mul_hi ? MA_W'(signed'(y_reg[XW-1:LO_W]))
                               : signed'({1'b0, y_reg[LO_W-1:0]});
    assign mx_p   = PW'(mx_a) * PW'(gain_s);
    assign my_p   = PW'(my_a) * PW'(gain_s);

    logic [POS_W-1:0]  gx_new, gy_new;
    logic [HEAD_W-1:0] gh_new;

    assign gx_new = gx_reg + POS_W'(ax_reg[AW-1:RSH]);
    assign gy_new = gy_reg + POS_W'(ay_reg[AW-1:RSH]);
    assign gh_new = gh_reg + turn_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gx_reg <= '0;
            gy_reg <= '0;
            gh_reg <= '0;
        end else begin
            priority if (cmd.load && start_new) begin
                gx_reg <= '0;
                gy_reg <= '0;
                gh_reg <= '0;
            end else if (cmd.commit) begin
                gx_reg <= gx_new;
                gy_reg <= gy_new;
                gh_reg <= gh_new;
            end else begin
                gx_reg <= gx_reg;
                gy_reg <= gy_reg;
                gh_reg <= gh_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg    <= x_init;
            y_reg    <= y_init;
            z_reg    <= ZW'(z_wide);
            turn_reg <= delta_heading;
        end
        if (cmd.rot) begin
            if (z_pos) begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - a_step;
            end else begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + a_step;
            end
        end
        if (cmd.mul_lo || cmd.mul_hi) begin
            px_reg <= mx_p;
            py_reg <= my_p;
        end
        if (cmd.mul_hi) begin
            // low partial product plus the rounding half
            ax_reg <= AW'(px_reg) + signed'(ROUND_C);
            ay_reg <= AW'(py_reg) + signed'(ROUND_C);
        end
        if (cmd.mul_sum) begin
            ax_reg <= ax_reg + (AW'(px_reg) <<< LO_W);
            ay_reg <= ay_reg + (AW'(py_reg) <<< LO_W);
        end
        if (cmd.commit) begin
            px_out_reg <= gx_new;
            py_out_reg <= gy_new;
            ph_out_reg <= gh_new;
        end
    end

    assign pose_x       = signed'(px_out_reg);
    assign pose_y       = signed'(py_out_reg);
    assign pose_heading = signed'(ph_out_reg);

endmodule

[verif/tb.sv]
// tb: self-checking bench for odometry_pose_integrator_unit, compares each pose against a
// cordic pose predictor under random gaps, long result hold-off and start_new resets
// depends on opi_pkg and the odometry_pose_integrator_unit rtl
module tb;
    import opi_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 64;
    localparam int REPORT_MAX   = 10;
    localparam int ROT_N        = (ROTATION_STEPS < 24) ? ROTATION_STEPS : 24;
    localparam longint INV_GAIN = 64'sd652032874;

    localparam logic [DELTA_W-1:0] DELTA_MAX = 24'h7FFFFF;
    localparam logic [DELTA_W-1:0] DELTA_MIN = 24'h800000;

    // arctangent of 2^-i in turns, 32 bits per circle
    localparam logic [31:0] ARCTAN_TURN [24] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
        32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    // same layout as m_tdata: x lowest
    typedef struct packed {
        logic [HEAD_W-1:0] heading;
        logic [POS_W-1:0]  y;
        logic [POS_W-1:0]  x;
    } pose_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;

    pose_t pose_now = '0;
    pose_t pose_due[$];
    int    mismatches = 0;
    logic  idle_on    = 1'b1;
    int    hold_ask   = 0;
    int    hold_taken = 0;
    int    hold_left  = 0;
    int    stall_left = 0;

    odometry_pose_integrator_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // fold by a half turn, then cordic rotation with guard bits and gain correction
    function automatic void rotate_to_world(input longint ox, input longint oy,
                                            input logic [HEAD_W-1:0] h,
                                            output longint wx, output longint wy);
        longint x, y, z, xs, ys, a;
        logic [HEAD_W-1:0] hh, probe;
        x  = ox <<< GUARD_BITS;
        y  = oy <<< GUARD_BITS;
        hh = h;
        probe = hh + 16'h4000;
        if (probe[HEAD_W-1]) begin
            x  = -x;
            y  = -y;
            hh = hh ^ 16'h8000;
        end
        z = longint'($signed(hh));
        if (ANGLE_BITS >= 16) z = z <<< (ANGLE_BITS - 16);
        else z = z >>> (16 - ANGLE_BITS);
        for (int i = 0; i < ROT_N; i++) begin
            a  = longint'(ARCTAN_TURN[i] >> (32 - ANGLE_BITS));
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - a;
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + a;
            end
        end
        wx = (x * INV_GAIN + (longint'(1) <<< (29 + GUARD_BITS))) >>> (30 + GUARD_BITS);
        wy = (y * INV_GAIN + (longint'(1) <<< (29 + GUARD_BITS))) >>> (30 + GUARD_BITS);
    endfunction

    function automatic void predict_pose(input logic start, input logic [DELTA_W-1:0] dx,
                                         input logic [DELTA_W-1:0] dy,
                                         input logic [HEAD_W-1:0] dh);
        longint wx, wy;
        if (start) pose_now = '0;
        rotate_to_world(longint'($signed(dx)), longint'($signed(dy)), pose_now.heading,
                        wx, wy);
        pose_now.x       = pose_now.x + wx[POS_W-1:0];
        pose_now.y       = pose_now.y + wy[POS_W-1:0];
        pose_now.heading = pose_now.heading + dh;
        pose_due = {pose_due, pose_now};
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("mismatch %s: expected %h, got %h", what, want, got);
    endtask

    task automatic send_step(input logic start, input logic [DELTA_W-1:0] dx,
                             input logic [DELTA_W-1:0] dy, input logic [HEAD_W-1:0] dh);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= start;
        s_tdata  <= {dh, dy, dx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_pose(start, dx, dy, dh);
    endtask

    function automatic logic [DELTA_W-1:0] rand_delta();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return DELTA_W'($urandom);
            5, 6, 7:       return DELTA_W'($urandom_range(0, 1 << 19)) - DELTA_W'(1 << 18);
            8:             return DELTA_MAX;
            default:       return DELTA_MIN;
        endcase
    endfunction

    function automatic logic [HEAD_W-1:0] rand_turn();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return HEAD_W'($urandom);
            4, 5, 6:    return HEAD_W'($urandom_range(0, 512)) - 16'd256;
            7:          return 16'h7FFF;
            8:          return 16'h8000;
            default:    return $urandom_range(0, 1) ? 16'h4000 : 16'hC000;
        endcase
    endfunction

    // result side: compare against oldest prediction, then pick next tready
    always @(posedge aclk) begin : result_side
        pose_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (pose_due.size() == 0) begin
                note_mismatch("unrequested pose x", '0, got.x);
            end else begin
                want = pose_due.pop_front();
                if (got.x !== want.x) note_mismatch("pose_x", want.x, got.x);
                if (got.y !== want.y) note_mismatch("pose_y", want.y, got.y);
                if (got.heading !== want.heading)
                    note_mismatch("pose_heading", want.heading, got.heading);
            end
        end
        if (hold_ask != hold_taken) begin
            hold_taken = hold_ask;
            hold_left  = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (idle_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    task automatic test_directed();
        send_step(1'b1, '0, '0, '0);
        send_step(1'b0, DELTA_MAX, '0, '0);
        send_step(1'b0, DELTA_MIN, '0, '0);
        send_step(1'b0, '0, DELTA_MAX, '0);
        send_step(1'b0, '0, DELTA_MIN, 16'h4000);
        // walk the heading across both fold boundaries
        send_step(1'b0, DELTA_MAX, DELTA_MAX, 16'hFFFF);
        send_step(1'b0, DELTA_MIN, DELTA_MIN, 16'h4001);
        send_step(1'b0, DELTA_MAX, DELTA_MIN, 16'h3FFF);
        send_step(1'b0, DELTA_MIN, DELTA_MAX, 16'h0001);
        send_step(1'b0, DELTA_MAX, DELTA_MAX, 16'h7FFF);
        send_step(1'b0, DELTA_MIN, DELTA_MIN, 16'h8000);
        send_step(1'b0, 24'hFFFFFF, 24'h000001, 16'h8000);
        // start flag in the middle of a trajectory
        send_step(1'b1, DELTA_MAX, DELTA_MIN, 16'h7FFF);
        send_step(1'b0, 24'h000001, 24'hFFFFFF, 16'h0001);
        send_step(1'b0, 24'h000001, '0, 16'h2000);
        send_step(1'b0, '0, 24'h000001, 16'h0000);
        send_step(1'b1, '0, '0, 16'h8000);
        send_step(1'b0, 24'h555555, 24'hAAAAAA, 16'h5555);
        send_step(1'b0, 24'hAAAAAA, 24'h555555, 16'hAAAA);
    endtask

    // long straight run so both position sums wrap
    task automatic test_position_wrap();
        send_step(1'b1, '0, '0, '0);
        repeat (270)
            send_step(1'b0, DELTA_MAX - DELTA_W'($urandom_range(0, 4095)),
                      DELTA_MIN + DELTA_W'($urandom_range(0, 4095)), '0);
    endtask

    task automatic test_random_walk();
        repeat (150)
            send_step($urandom_range(0, 19) == 0, rand_delta(), rand_delta(), rand_turn());
    endtask

    // receiver holds off while requests keep coming, so the input stalls
    task automatic test_backpressure();
        idle_on  = 1'b0;
        hold_ask <= hold_ask + 1;
        repeat (12) send_step(1'b0, rand_delta(), rand_delta(), rand_turn());
        idle_on  = 1'b1;
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        repeat (40) send_step($urandom_range(0, 9) == 0, rand_delta(), rand_delta(),
                              rand_turn());
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_position_wrap();
        test_random_walk();
        test_backpressure();
        test_back_to_back();
        s_tvalid <= 1'b0;
        while (pose_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("tb: done, errors");
        $finish;
    end

endmodule
